// File: hdl/abpm_pkg.sv
`default_nettype none
package abpm_pkg;

  // Pool geometry.
  localparam int POOL_SLOTS = 64;
  localparam int MAX_MIPS   = 15;
  localparam int SLOT_W     = $clog2(POOL_SLOTS);
  localparam int CNT_W      = $clog2(POOL_SLOTS + 1);

  // Field and entry widths.
  localparam int OP_W      = 2;
  localparam int KEY_W     = 32;
  localparam int EXT_W     = 15;
  localparam int DEPTH_W   = 12;
  localparam int MIPS_W    = 4;
  localparam int BPP_W     = 8;
  localparam int REL_W     = 6;
  localparam int OSLOT_W   = 6;
  localparam int EVICT_W   = 7;
  localparam int FLOOR_W   = 16;
  localparam int SIZE_W    = 36;
  localparam int IDLE_W    = 8;
  localparam int TOTAL_W   = 41;
  localparam int SUM_W     = SIZE_W + SLOT_W;
  localparam int LVL_W     = $clog2(MAX_MIPS + 1) + 1;
  localparam int P1_W      = 2 * EXT_W;
  localparam int P2_W      = DEPTH_W + BPP_W;
  localparam int PROD_W    = P1_W + P2_W;
  localparam int BYTES_W   = PROD_W + 1;
  localparam int KBSUM_W   = BYTES_W + 1;

  // Constants of the size and aging rules.
  localparam logic [BYTES_W-1:0] BYTE_ROUND = BYTES_W'(7);
  localparam int                 BYTE_SHIFT = 3;
  localparam logic [KBSUM_W-1:0] KB_ROUND   = KBSUM_W'(1023);
  localparam int                 KB_SHIFT   = 10;
  localparam logic [SIZE_W-1:0]  SIZE_MAX   = {SIZE_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX  = {TOTAL_W{1'b1}};
  localparam logic [IDLE_W-1:0]  IDLE_MAX   = {IDLE_W{1'b1}};
  localparam logic [IDLE_W-1:0]  AGE_LIMIT  = IDLE_W'(2);
  localparam logic [EVICT_W-1:0] EVICT_MAX  = {EVICT_W{1'b1}};

  // Configuration port.
  localparam int                ADDR_W     = 3;
  localparam logic [ADDR_W-1:0] ADDR_FLOOR = ADDR_W'(0);

  typedef enum logic [OP_W-1:0] {
    OP_REQUEST = 2'd0,
    OP_RELEASE = 2'd1,
    OP_TICK    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    SCAN_REQ   = 2'd0,
    SCAN_AGE   = 2'd1,
    SCAN_EVICT = 2'd2
  } scan_mode_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       scan_start;
    logic       scan_run;
    scan_mode_t scan_mode;
    logic       release_slot;
    logic       hit_write;
    logic       size_init;
    logic       size_mul1;
    logic       size_mul2;
    logic       size_acc;
    logic       size_fin;
    logic       alloc;
    logic       refuse;
    logic       rd_old;
    logic       evict;
    logic       out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic scan_done;
    logic hit_found;
    logic free_found;
    logic old_found;
    logic lvl_zero;
    logic over_floor;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// File: hdl/abpm_ctrl.sv
`default_nettype none
module abpm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  output abpm_pkg::cmd_t     cmd,
  input  wire abpm_pkg::sts_t sts
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_REQ_SCAN,
    S_REQ_DECIDE,
    S_SZ_CHK,
    S_SZ_M1,
    S_SZ_M2,
    S_SZ_ACC,
    S_SZ_FIN,
    S_ALLOC,
    S_AGE_SCAN,
    S_EV_CHK,
    S_EV_SCAN,
    S_EV_DECIDE,
    S_EV_DO,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
        if (in_valid) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.op)
          abpm_pkg::OP_REQUEST: begin
            cmd.scan_start = 1'b1;
            state_next     = S_REQ_SCAN;
          end
          abpm_pkg::OP_RELEASE: begin
            cmd.release_slot = 1'b1;
            state_next       = S_FINISH;
          end
          abpm_pkg::OP_TICK: begin
            cmd.scan_start = 1'b1;
            state_next     = S_AGE_SCAN;
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_REQ_SCAN: begin
        cmd.scan_run  = 1'b1;
        cmd.scan_mode = abpm_pkg::SCAN_REQ;
        if (sts.scan_done) begin
          state_next = S_REQ_DECIDE;
        end
      end
      S_REQ_DECIDE: begin
        if (sts.hit_found) begin
          cmd.hit_write = 1'b1;
          state_next    = S_FINISH;
        end else if (sts.free_found) begin
          cmd.size_init = 1'b1;
          state_next    = S_SZ_CHK;
        end else begin
          cmd.refuse = 1'b1;
          state_next = S_FINISH;
        end
      end
      S_SZ_CHK: begin
        state_next = sts.lvl_zero ? S_SZ_FIN : S_SZ_M1;
      end
      S_SZ_M1: begin
        cmd.size_mul1 = 1'b1;
        state_next    = S_SZ_M2;
      end
      S_SZ_M2: begin
        cmd.size_mul2 = 1'b1;
        state_next    = S_SZ_ACC;
      end
      S_SZ_ACC: begin
        cmd.size_acc = 1'b1;
        state_next   = S_SZ_CHK;
      end
      S_SZ_FIN: begin
        cmd.size_fin = 1'b1;
        state_next   = S_ALLOC;
      end
      S_ALLOC: begin
        cmd.alloc  = 1'b1;
        state_next = S_FINISH;
      end
      S_AGE_SCAN: begin
        cmd.scan_run  = 1'b1;
        cmd.scan_mode = abpm_pkg::SCAN_AGE;
        if (sts.scan_done) begin
          state_next = S_EV_CHK;
        end
      end
      S_EV_CHK: begin
        if (sts.over_floor) begin
          cmd.scan_start = 1'b1;
          state_next     = S_EV_SCAN;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_EV_SCAN: begin
        cmd.scan_run  = 1'b1;
        cmd.scan_mode = abpm_pkg::SCAN_EVICT;
        if (sts.scan_done) begin
          state_next = S_EV_DECIDE;
        end
      end
      S_EV_DECIDE: begin
        cmd.rd_old = 1'b1;
        state_next = sts.old_found ? S_EV_DO : S_FINISH;
      end
      S_EV_DO: begin
        cmd.evict  = 1'b1;
        state_next = S_EV_CHK;
      end
      S_FINISH: begin
        cmd.out_load = sts.out_free;
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// File: hdl/abpm_dp.sv
`default_nettype none
module abpm_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire abpm_pkg::cmd_t                    cmd,
  output abpm_pkg::sts_t                         sts,
  input  wire logic [abpm_pkg::OP_W-1:0]         op,
  input  wire logic [abpm_pkg::KEY_W-1:0]        key,
  input  wire logic [abpm_pkg::EXT_W-1:0]        width,
  input  wire logic [abpm_pkg::EXT_W-1:0]        height,
  input  wire logic [abpm_pkg::DEPTH_W-1:0]      depth,
  input  wire logic [abpm_pkg::MIPS_W-1:0]       mip_levels,
  input  wire logic [abpm_pkg::BPP_W-1:0]        bits_per_pixel,
  input  wire logic [abpm_pkg::REL_W-1:0]        release_slot,
  input  wire logic [abpm_pkg::FLOOR_W-1:0]      floor_mb,
  input  wire logic                              out_stall,
  output logic                                   out_valid,
  output logic [abpm_pkg::OSLOT_W-1:0]           slot,
  output logic                                   hit,
  output logic                                   status,
  output logic [abpm_pkg::EVICT_W-1:0]           evicted,
  output logic [abpm_pkg::TOTAL_W-1:0]           pool_kb
);

  // Captured input item.
  logic [abpm_pkg::OP_W-1:0]    c_op;
  logic [abpm_pkg::KEY_W-1:0]   c_key;
  logic [abpm_pkg::EXT_W-1:0]   c_w;
  logic [abpm_pkg::EXT_W-1:0]   c_h;
  logic [abpm_pkg::DEPTH_W-1:0] c_d;
  logic [abpm_pkg::MIPS_W-1:0]  c_mips;
  logic [abpm_pkg::BPP_W-1:0]   c_bpp;
  logic [abpm_pkg::REL_W-1:0]   c_rel;

  // Per-slot flags and entry memories.
  logic [abpm_pkg::POOL_SLOTS-1:0] valid_q;
  logic [abpm_pkg::POOL_SLOTS-1:0] busy_q;
  logic [abpm_pkg::KEY_W-1:0]  key_mem  [abpm_pkg::POOL_SLOTS];
  logic [abpm_pkg::SIZE_W-1:0] size_mem [abpm_pkg::POOL_SLOTS];
  logic [abpm_pkg::IDLE_W-1:0] idle_mem [abpm_pkg::POOL_SLOTS];
  logic [abpm_pkg::KEY_W-1:0]  key_rd;
  logic [abpm_pkg::SIZE_W-1:0] size_rd;
  logic [abpm_pkg::IDLE_W-1:0] idle_rd;
  logic [abpm_pkg::SLOT_W-1:0] rd_addr;

  // Scan engine.
  logic [abpm_pkg::CNT_W-1:0]  cnt;
  logic                        sv;
  logic [abpm_pkg::SLOT_W-1:0] sidx;

  // Search results.
  logic                        hit_found;
  logic [abpm_pkg::SLOT_W-1:0] hit_idx;
  logic                        free_found;
  logic [abpm_pkg::SLOT_W-1:0] free_idx;
  logic                        old_found;
  logic [abpm_pkg::SLOT_W-1:0] old_idx;
  logic [abpm_pkg::IDLE_W-1:0] old_idle;

  // Size unit.
  logic [abpm_pkg::EXT_W-1:0]   sw;
  logic [abpm_pkg::EXT_W-1:0]   sh;
  logic [abpm_pkg::DEPTH_W-1:0] sd;
  logic [abpm_pkg::BPP_W-1:0]   sbpp;
  logic [abpm_pkg::LVL_W-1:0]   lvl_left;
  logic [abpm_pkg::P1_W-1:0]    p1;
  logic [abpm_pkg::P2_W-1:0]    p2;
  logic [abpm_pkg::PROD_W-1:0]  p3;
  logic [abpm_pkg::BYTES_W-1:0] bytes;
  logic [abpm_pkg::SIZE_W-1:0]  size_kb;
  logic [abpm_pkg::KBSUM_W-1:0] kb_full;

  // Totals and results.
  logic [abpm_pkg::SUM_W-1:0]   raw_sum;
  logic [abpm_pkg::TOTAL_W-1:0] total_sat;
  logic [abpm_pkg::SLOT_W-1:0]  res_slot;
  logic                         res_hit;
  logic                         res_status;
  logic [abpm_pkg::EVICT_W-1:0] res_evicted;

  logic                         scan_hit;
  logic                         idle_we;
  logic [abpm_pkg::SLOT_W-1:0]  idle_wa;
  logic [abpm_pkg::IDLE_W-1:0]  idle_wd;
  logic [abpm_pkg::SLOT_W-1:0]  rel_idx;
  logic                         rel_ok;

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_op   <= op;
      c_key  <= key;
      c_w    <= width;
      c_h    <= height;
      c_d    <= depth;
      c_mips <= mip_levels;
      c_bpp  <= bits_per_pixel;
      c_rel  <= release_slot;
    end
  end

  // One read address: the scan position, or the chosen victim.
  assign rd_addr = cmd.rd_old ? old_idx : cnt[abpm_pkg::SLOT_W-1:0];

  // The idle counter has one write port shared by aging, reuse and allocation.
  assign scan_hit = cmd.scan_run && sv;
  always_comb begin
    idle_we = 1'b0;
    idle_wa = free_idx;
    idle_wd = '0;
    if (cmd.alloc) begin
      idle_we = 1'b1;
    end else if (cmd.hit_write) begin
      idle_we = 1'b1;
      idle_wa = hit_idx;
    end else if (scan_hit && cmd.scan_mode == abpm_pkg::SCAN_AGE && valid_q[sidx] &&
                 idle_rd != abpm_pkg::IDLE_MAX) begin
      idle_we = 1'b1;
      idle_wa = sidx;
      idle_wd = idle_rd + abpm_pkg::IDLE_W'(1);
    end
  end

  // Entry memories with registered reads.
  always_ff @(posedge clk) begin
    key_rd  <= key_mem[rd_addr];
    size_rd <= size_mem[rd_addr];
    idle_rd <= idle_mem[rd_addr];
    if (cmd.alloc) begin
      key_mem[free_idx]  <= c_key;
      size_mem[free_idx] <= size_kb;
    end
    if (idle_we) begin
      idle_mem[idle_wa] <= idle_wd;
    end
  end

  // Scan counter; the stage behind it sees the read data of slot sidx.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      sv  <= 1'b0;
    end else if (cmd.scan_start) begin
      cnt <= '0;
      sv  <= 1'b0;
    end else if (cmd.scan_run) begin
      sv <= (cnt < abpm_pkg::CNT_W'(abpm_pkg::POOL_SLOTS));
      if (cnt < abpm_pkg::CNT_W'(abpm_pkg::POOL_SLOTS)) begin
        cnt <= cnt + abpm_pkg::CNT_W'(1);
      end
    end else begin
      sv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    sidx <= cnt[abpm_pkg::SLOT_W-1:0];
  end

  // Searches: first reusable match, first free slot, oldest aged slot.
  always_ff @(posedge clk) begin
    if (rst || cmd.scan_start) begin
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      old_found  <= 1'b0;
    end else if (scan_hit) begin
      if (cmd.scan_mode == abpm_pkg::SCAN_REQ) begin
        if (!hit_found && valid_q[sidx] && !busy_q[sidx] && key_rd == c_key) begin
          hit_found <= 1'b1;
        end
        if (!free_found && !valid_q[sidx]) begin
          free_found <= 1'b1;
        end
      end else if (cmd.scan_mode == abpm_pkg::SCAN_EVICT) begin
        if (valid_q[sidx] && idle_rd > abpm_pkg::AGE_LIMIT &&
            (!old_found || idle_rd > old_idle)) begin
          old_found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_hit) begin
      if (cmd.scan_mode == abpm_pkg::SCAN_REQ) begin
        if (!hit_found && valid_q[sidx] && !busy_q[sidx] && key_rd == c_key) begin
          hit_idx <= sidx;
        end
        if (!free_found && !valid_q[sidx]) begin
          free_idx <= sidx;
        end
      end else if (cmd.scan_mode == abpm_pkg::SCAN_EVICT) begin
        if (valid_q[sidx] && idle_rd > abpm_pkg::AGE_LIMIT &&
            (!old_found || idle_rd > old_idle)) begin
          old_idx  <= sidx;
          old_idle <= idle_rd;
        end
      end
    end
  end

  // Valid and busy flags.
  assign rel_idx = abpm_pkg::SLOT_W'(c_rel);
  assign rel_ok  = abpm_pkg::CNT_W'(c_rel) < abpm_pkg::CNT_W'(abpm_pkg::POOL_SLOTS);
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
      busy_q  <= '0;
    end else begin
      if (cmd.release_slot && rel_ok && valid_q[rel_idx]) begin
        busy_q[rel_idx] <= 1'b0;
      end
      if (cmd.hit_write) begin
        busy_q[hit_idx] <= 1'b1;
      end
      if (cmd.alloc) begin
        valid_q[free_idx] <= 1'b1;
        busy_q[free_idx]  <= 1'b1;
      end
      if (cmd.evict) begin
        valid_q[old_idx] <= 1'b0;
        busy_q[old_idx]  <= 1'b0;
      end
    end
  end

  // Size unit: each mip level passes four steps (check, two multiply steps, accumulate).
  assign kb_full = (abpm_pkg::KBSUM_W'(bytes) + abpm_pkg::KB_ROUND) >> abpm_pkg::KB_SHIFT;
  always_ff @(posedge clk) begin
    if (cmd.size_init) begin
      sw    <= c_w;
      sh    <= c_h;
      sd    <= c_d;
      sbpp  <= c_bpp;
      bytes <= '0;
      if (abpm_pkg::LVL_W'(c_mips) > abpm_pkg::LVL_W'(abpm_pkg::MAX_MIPS)) begin
        lvl_left <= abpm_pkg::LVL_W'(abpm_pkg::MAX_MIPS);
      end else begin
        lvl_left <= abpm_pkg::LVL_W'(c_mips);
      end
    end
    if (cmd.size_mul1) begin
      p1 <= abpm_pkg::P1_W'(sw) * abpm_pkg::P1_W'(sh);
      p2 <= abpm_pkg::P2_W'(sd) * abpm_pkg::P2_W'(sbpp);
    end
    if (cmd.size_mul2) begin
      p3 <= abpm_pkg::PROD_W'(p1) * abpm_pkg::PROD_W'(p2);
    end
    if (cmd.size_acc) begin
      bytes    <= bytes + ((abpm_pkg::BYTES_W'(p3) + abpm_pkg::BYTE_ROUND)
                           >> abpm_pkg::BYTE_SHIFT);
      sw       <= sw >> 1;
      sh       <= sh >> 1;
      sd       <= sd >> 1;
      lvl_left <= lvl_left - abpm_pkg::LVL_W'(1);
    end
    if (cmd.size_fin) begin
      if (kb_full > abpm_pkg::KBSUM_W'(abpm_pkg::SIZE_MAX)) begin
        size_kb <= abpm_pkg::SIZE_MAX;
      end else begin
        size_kb <= abpm_pkg::SIZE_W'(kb_full);
      end
    end
  end

  // Exact sum of valid sizes; the reported total saturates.
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_sum <= '0;
    end else if (cmd.alloc) begin
      raw_sum <= raw_sum + abpm_pkg::SUM_W'(size_kb);
    end else if (cmd.evict) begin
      raw_sum <= raw_sum - abpm_pkg::SUM_W'(size_rd);
    end
  end
  assign total_sat = (raw_sum > abpm_pkg::SUM_W'(abpm_pkg::TOTAL_MAX)) ?
                     abpm_pkg::TOTAL_MAX : abpm_pkg::TOTAL_W'(raw_sum);

  // Result fields of the item in flight.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_slot    <= '0;
      res_hit     <= 1'b0;
      res_status  <= 1'b0;
      res_evicted <= '0;
    end else begin
      if (cmd.hit_write) begin
        res_slot <= hit_idx;
        res_hit  <= 1'b1;
      end
      if (cmd.alloc) begin
        res_slot <= free_idx;
      end
      if (cmd.refuse) begin
        res_status <= 1'b1;
      end
      if (cmd.evict && res_evicted != abpm_pkg::EVICT_MAX) begin
        res_evicted <= res_evicted + abpm_pkg::EVICT_W'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      slot    <= abpm_pkg::OSLOT_W'(res_slot);
      hit     <= res_hit;
      status  <= res_status;
      evicted <= res_evicted;
      pool_kb <= total_sat;
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.op         = abpm_pkg::op_t'(c_op);
    sts.scan_done  = (cnt == abpm_pkg::CNT_W'(abpm_pkg::POOL_SLOTS)) && !sv;
    sts.hit_found  = hit_found;
    sts.free_found = free_found;
    sts.old_found  = old_found;
    sts.lvl_zero   = (lvl_left == '0);
    sts.over_floor = total_sat > (abpm_pkg::TOTAL_W'(floor_mb) << abpm_pkg::KB_SHIFT);
    sts.out_free   = !out_valid || !out_stall;
  end

endmodule
`default_nettype wire

// File: hdl/aged_buffer_pool_manager.sv
// Channel   Direction  Handshake            Beat contents
// in        input      in_valid / in_stall  op, key, width, height, depth, mip_levels,
//                                           bits_per_pixel, release_slot
// out       output     out_valid/out_stall  slot, hit, status, evicted, pool_kb
// apb       input      psel/penable/pready  pool_floor_mb at byte address 0
//
// One item is worked at a time; every slot scan walks the entry memories one slot a cycle.
// A request scans every slot, then is reused, refused or given a free slot.
// A new allocation then sizes the entry, working one mip level at a time.
// A release only clears a busy flag; a tick runs an aging scan, then eviction scans while over the floor.
// Reset clears all valid and busy flags and the total; no clearing pass is needed.
// A beat waiting on out_stall does not block the next input beat from being accepted.
`default_nettype none
module aged_buffer_pool_manager (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [abpm_pkg::OP_W-1:0]         op,
  input  wire logic [abpm_pkg::KEY_W-1:0]        key,
  input  wire logic [abpm_pkg::EXT_W-1:0]        width,
  input  wire logic [abpm_pkg::EXT_W-1:0]        height,
  input  wire logic [abpm_pkg::DEPTH_W-1:0]      depth,
  input  wire logic [abpm_pkg::MIPS_W-1:0]       mip_levels,
  input  wire logic [abpm_pkg::BPP_W-1:0]        bits_per_pixel,
  input  wire logic [abpm_pkg::REL_W-1:0]        release_slot,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [abpm_pkg::OSLOT_W-1:0]           slot,
  output logic                                   hit,
  output logic                                   status,
  output logic [abpm_pkg::EVICT_W-1:0]           evicted,
  output logic [abpm_pkg::TOTAL_W-1:0]           pool_kb,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [abpm_pkg::ADDR_W-1:0]       paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  abpm_pkg::cmd_t                 cmd;
  abpm_pkg::sts_t                 sts;
  logic [abpm_pkg::FLOOR_W-1:0]   pool_floor_mb;

  // Configuration register.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_floor_mb <= '0;
    end else if (psel && penable && pwrite && pready && paddr == abpm_pkg::ADDR_FLOOR) begin
      pool_floor_mb <= pwdata[abpm_pkg::FLOOR_W-1:0];
    end
  end
  assign prdata = (paddr == abpm_pkg::ADDR_FLOOR) ? 32'(pool_floor_mb) : '0;

  abpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  abpm_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .op             (op),
    .key            (key),
    .width          (width),
    .height         (height),
    .depth          (depth),
    .mip_levels     (mip_levels),
    .bits_per_pixel (bits_per_pixel),
    .release_slot   (release_slot),
    .floor_mb       (pool_floor_mb),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .slot           (slot),
    .hit            (hit),
    .status         (status),
    .evicted        (evicted),
    .pool_kb        (pool_kb)
  );

  // Once a beat is taken, the block is busy with it in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice in a row");

  // A refused request grants nothing.
  a_refuse_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (slot == '0 && !hit && evicted == '0))
    else $error("refused request carries a grant");

  // Evictions only come with a tick, which grants no slot.
  a_evict_no_grant: assert property (@(posedge clk) disable iff (rst)
    (out_valid && evicted != '0) |-> (slot == '0 && !hit && !status))
    else $error("eviction count on a request result");

  // A result is loaded only while the block is busy with an item.
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in flight");

endmodule
`default_nettype wire
